/* rtl/gmdt_pkg.sv */
// ----------------------------------------------------------------------------
// gmdt_pkg: shared types and constants for the grid distance transform
// Grid limits, store geometry, beat payload types and small helpers.
// ----------------------------------------------------------------------------
package gmdt_pkg;

   localparam int MAX_ROWS    = 128;
   localparam int MAX_COLS    = 128;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
   localparam int MAX_DIM     = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int DIM_W       = $clog2(MAX_DIM + 1);
   localparam int COL_IW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DIST_W      = $clog2(MAX_ROWS + MAX_COLS) + 1;
   localparam int CSR_AW      = 3;

   localparam logic [DIST_W-1:0] DIST_INF  = {DIST_W{1'b1}};
   localparam logic [7:0]        DIST_NONE = 8'd255;
   localparam logic [7:0]        DIST_CAP  = 8'd254;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   typedef struct packed {
      logic command;
      logic cell_bit;
   } req_type;

   typedef struct packed {
      logic [7:0] distance;
      logic       no_source;
      logic       last;
   } rsp_type;

   // A size of zero counts as one, and anything above the limit as the limit.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [7:0] v, input int maxv);
      logic [31:0] wide;
      wide = {24'd0, v};
      if (v == 8'd0) begin
         clamp_dim = DIM_W'(1);
      end else if (wide > 32'(maxv)) begin
         clamp_dim = DIM_W'(maxv);
      end else begin
         clamp_dim = DIM_W'(wide);
      end
   endfunction

   // Increment that sticks at the unreached marker.
   function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] v);
      sat_inc = (v == DIST_INF) ? DIST_INF : v + DIST_W'(1);
   endfunction

   function automatic logic [DIST_W-1:0] min2(input logic [DIST_W-1:0] a,
                                              input logic [DIST_W-1:0] b);
      min2 = (a < b) ? a : b;
   endfunction

endpackage

/* rtl/grid_manhattan_distance_transform_unit.sv */
// ----------------------------------------------------------------------------
// grid_manhattan_distance_transform_unit: city-block distance transform
// A load beat is taken while the unit stays idle; a fetch beat on computed distances
// passes through the output state and back to idle. The first fetch after loading runs
// a forward and a backward raster sweep, reading one cell store entry per cycle.
// Reset is synchronous; the result strobe cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module grid_manhattan_distance_transform_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_start,
   output logic                       req_busy,
   input  gmdt_pkg::req_type          req_data,
   output logic                       rsp_strobe,
   output gmdt_pkg::rsp_type          rsp_data,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [gmdt_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);
   import gmdt_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FWD, ST_FWD_DRAIN, ST_BWD, ST_BWD_DRAIN, ST_FETCH_SETUP, ST_FETCH_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [7:0]        rows_reg_ff, cols_reg_ff;
   logic [CNT_W-1:0]  load_ptr_ff, load_ptr_in;
   logic [CNT_W-1:0]  fetch_ptr_ff, fetch_ptr_in;
   logic [CNT_W-1:0]  grid_cells_ff, grid_cells_in;
   logic              computed_ff, computed_in;
   logic              src_ff, src_in;
   logic [DIM_W-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [ADDR_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0]  r_ff, r_in, c_ff, c_in;
   logic              v1_ff, v1_in;
   logic [ADDR_W-1:0] k1_ff;
   logic [DIM_W-1:0]  r1_ff, c1_ff;
   logic              inr1_ff;
   logic [DIST_W-1:0] prev_ff;

   logic [DIM_W-1:0]  rows_now, cols_now;
   logic [CNT_W-1:0]  cells_now;
   logic              accept, csr_wr;
   logic              cell_we;
   logic [ADDR_W-1:0] cell_waddr;
   logic              cell_rd;
   logic [DIST_W-1:0] dist_rd, tap, sweep_d;
   logic [ADDR_W-1:0] dist_raddr;
   logic              fwd_mode;
   logic [DIST_W-1:0] near_a, near_b;

   assign rows_now  = clamp_dim(rows_reg_ff, MAX_ROWS);
   assign cols_now  = clamp_dim(cols_reg_ff, MAX_COLS);
   assign cells_now = CNT_W'(rows_now) * CNT_W'(cols_now);
   assign accept    = req_start && !req_busy;
   assign req_busy  = (state_ff != ST_IDLE);

   // Configuration port.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_reg_ff <= 8'd128;
         cols_reg_ff <= 8'd128;
      end else if (csr_wr) begin
         if (paddr[2] == REG_ROWS) begin
            rows_reg_ff <= pwdata[7:0];
         end else begin
            cols_reg_ff <= pwdata[7:0];
         end
      end
   end
   assign prdata = (paddr[2] == REG_COLS) ? {24'd0, cols_reg_ff} : {24'd0, rows_reg_ff};

   // Cell store: entries at or beyond the load count are treated as non-source cells.
   always_comb begin
      cell_we    = 1'b0;
      cell_waddr = '0;
      if (state_ff == ST_IDLE && accept && req_data.command == CMD_LOAD) begin
         if (computed_ff) begin
            cell_we = 1'b1;
         end else if (load_ptr_ff < cells_now) begin
            cell_we    = 1'b1;
            cell_waddr = load_ptr_ff[ADDR_W-1:0];
         end
      end
   end

   gmdt_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_cell_ram (
      .clock(clock), .wr_en(cell_we), .wr_addr(cell_waddr), .wr_data(req_data.cell_bit),
      .rd_addr(k_ff), .rd_data(cell_rd)
   );

   // Sweep stage: combine this cell with its left/up or right/down neighbor.
   assign fwd_mode = (state_ff == ST_FWD) || (state_ff == ST_FWD_DRAIN);

   gmdt_chain u_chain (
      .clock(clock), .shift(v1_ff), .d_in(sweep_d),
      .tap_sel(COL_IW'(cols_ff - DIM_W'(1))), .tap_out(tap)
   );

   always_comb begin
      if (fwd_mode) begin
         near_a  = (r1_ff == '0) ? DIST_INF : sat_inc(tap);
         near_b  = (c1_ff == '0) ? DIST_INF : sat_inc(prev_ff);
         sweep_d = (inr1_ff && cell_rd) ? '0 : min2(near_a, near_b);
      end else begin
         near_a  = (r1_ff == rows_ff - DIM_W'(1)) ? DIST_INF : sat_inc(tap);
         near_b  = (c1_ff == cols_ff - DIM_W'(1)) ? DIST_INF : sat_inc(prev_ff);
         sweep_d = min2(dist_rd, min2(near_a, near_b));
      end
   end

   assign dist_raddr = (state_ff == ST_BWD) ? k_ff : fetch_ptr_ff[ADDR_W-1:0];

   gmdt_ram #(.WIDTH(DIST_W), .DEPTH(STORE_DEPTH)) u_dist_ram (
      .clock(clock), .wr_en(v1_ff), .wr_addr(k1_ff), .wr_data(sweep_d),
      .rd_addr(dist_raddr), .rd_data(dist_rd)
   );

   // Control sequencer.
   always_comb begin
      state_in      = state_ff;
      load_ptr_in   = load_ptr_ff;
      fetch_ptr_in  = fetch_ptr_ff;
      grid_cells_in = grid_cells_ff;
      computed_in   = computed_ff;
      src_in        = src_ff;
      rows_in       = rows_ff;
      cols_in       = cols_ff;
      k_in          = k_ff;
      r_in          = r_ff;
      c_in          = c_ff;
      v1_in         = 1'b0;
      if (v1_ff && fwd_mode && inr1_ff && cell_rd) begin
         src_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.command == CMD_LOAD) begin
                  if (computed_ff) begin
                     load_ptr_in = CNT_W'(1);
                     computed_in = 1'b0;
                  end else if (load_ptr_ff < cells_now) begin
                     load_ptr_in = load_ptr_ff + CNT_W'(1);
                  end
               end else if (computed_ff) begin
                  state_in = ST_FETCH_OUT;
               end else begin
                  state_in = ST_FWD;
                  rows_in  = rows_now;
                  cols_in  = cols_now;
                  grid_cells_in = cells_now;
                  src_in   = 1'b0;
                  k_in     = '0;
                  r_in     = '0;
                  c_in     = '0;
               end
            end
         end
         ST_FWD: begin
            v1_in = 1'b1;
            if (CNT_W'(k_ff) == grid_cells_ff - CNT_W'(1)) begin
               state_in = ST_FWD_DRAIN;
            end else begin
               k_in = k_ff + ADDR_W'(1);
               if (c_ff == cols_ff - DIM_W'(1)) begin
                  c_in = '0;
                  r_in = r_ff + DIM_W'(1);
               end else begin
                  c_in = c_ff + DIM_W'(1);
               end
            end
         end
         ST_FWD_DRAIN: begin
            state_in = ST_BWD;
            k_in     = ADDR_W'(grid_cells_ff - CNT_W'(1));
            r_in     = rows_ff - DIM_W'(1);
            c_in     = cols_ff - DIM_W'(1);
         end
         ST_BWD: begin
            v1_in = 1'b1;
            if (k_ff == '0) begin
               state_in = ST_BWD_DRAIN;
            end else begin
               k_in = k_ff - ADDR_W'(1);
               if (c_ff == '0) begin
                  c_in = cols_ff - DIM_W'(1);
                  r_in = r_ff - DIM_W'(1);
               end else begin
                  c_in = c_ff - DIM_W'(1);
               end
            end
         end
         ST_BWD_DRAIN: begin
            state_in     = ST_FETCH_SETUP;
            computed_in  = 1'b1;
            fetch_ptr_in = '0;
         end
         ST_FETCH_SETUP: begin
            state_in = ST_FETCH_OUT;
         end
         ST_FETCH_OUT: begin
            state_in     = ST_IDLE;
            fetch_ptr_in = (fetch_ptr_ff + CNT_W'(1) == grid_cells_ff) ? '0
                                                                       : fetch_ptr_ff + CNT_W'(1);
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_ptr_ff   <= '0;
         fetch_ptr_ff  <= '0;
         grid_cells_ff <= CNT_W'(1);
         computed_ff   <= 1'b0;
         src_ff        <= 1'b0;
         v1_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_ptr_ff   <= load_ptr_in;
         fetch_ptr_ff  <= fetch_ptr_in;
         grid_cells_ff <= grid_cells_in;
         computed_ff   <= computed_in;
         src_ff        <= src_in;
         v1_ff         <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      rows_ff <= rows_in;
      cols_ff <= cols_in;
      k_ff    <= k_in;
      r_ff    <= r_in;
      c_ff    <= c_in;
      k1_ff   <= k_ff;
      r1_ff   <= r_ff;
      c1_ff   <= c_ff;
      inr1_ff <= (CNT_W'(k_ff) < load_ptr_ff);
      if (v1_ff) begin
         prev_ff <= sweep_d;
      end
   end

   // Result beat.
   assign rsp_strobe = (state_ff == ST_FETCH_OUT);
   always_comb begin
      rsp_data.no_source = !src_ff;
      rsp_data.last      = (fetch_ptr_ff + CNT_W'(1) == grid_cells_ff);
      if (!src_ff) begin
         rsp_data.distance = DIST_NONE;
      end else if (dist_rd > DIST_W'(DIST_CAP)) begin
         rsp_data.distance = DIST_CAP;
      end else begin
         rsp_data.distance = 8'(dist_rd);
      end
   end

endmodule

/* rtl/gmdt_ram.sv */
// ----------------------------------------------------------------------------
// gmdt_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gmdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/gmdt_cell.sv */
// ----------------------------------------------------------------------------
// gmdt_cell: one element of the row delay chain
// Holds one distance and passes it to the next cell on every shift.
// ----------------------------------------------------------------------------
module gmdt_cell (
   input  logic                       clock,
   input  logic                       shift,
   input  logic [gmdt_pkg::DIST_W-1:0] d_in,
   output logic [gmdt_pkg::DIST_W-1:0] q_out
);
   import gmdt_pkg::*;

   logic [DIST_W-1:0] value_ff;

   always_ff @(posedge clock) begin
      if (shift) begin
         value_ff <= d_in;
      end
   end

   assign q_out = value_ff;

endmodule

/* rtl/gmdt_chain.sv */
// ----------------------------------------------------------------------------
// gmdt_chain: row of cells that delays sweep results by one grid row
// The tap picks the cell that holds the value one row back.
// ----------------------------------------------------------------------------
module gmdt_chain (
   input  logic                        clock,
   input  logic                        shift,
   input  logic [gmdt_pkg::DIST_W-1:0] d_in,
   input  logic [gmdt_pkg::COL_IW-1:0] tap_sel,
   output logic [gmdt_pkg::DIST_W-1:0] tap_out
);
   import gmdt_pkg::*;

   logic [DIST_W-1:0] q [MAX_COLS];

   for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
      if (i == 0) begin : g_head
         gmdt_cell u_cell (.clock(clock), .shift(shift), .d_in(d_in), .q_out(q[i]));
      end else begin : g_body
         gmdt_cell u_cell (.clock(clock), .shift(shift), .d_in(q[i-1]), .q_out(q[i]));
      end
   end

   assign tap_out = q[tap_sel];

endmodule
